// File: design/assert_macros.svh
// assertion macros shared by the checker files
// clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define RRAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rrar assertion failed");

// expression must never be true
`define RRAR_ASSERT_NEVER(lbl, expr) \
  `RRAR_ASSERT(lbl, !(expr))

`endif

// File: design/rrar_pkg.sv
// shared types and constants of the rational rate resampler
// no dependencies
package rrar_pkg;

  localparam int RateW      = 18;
  localparam int CfgIdxW    = 2;
  localparam int MaxResults = 64;
  localparam int EmitCntW   = $clog2(MaxResults + 1);

  localparam logic [RateW-1:0]   RateReset    = RateW'(48000);
  localparam logic [CfgIdxW-1:0] CFG_SRC_RATE = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_DST_RATE = CfgIdxW'(1);

  typedef enum logic [1:0] {
    MODE_UP_INT,
    MODE_DN_INT,
    MODE_FRAC
  } mode_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_RDIV,
    OP_RSET,
    OP_ACC,
    OP_EMIT_X,
    OP_CROSS_PA,
    OP_MUL1,
    OP_MUL2,
    OP_BDIV,
    OP_ADIV,
    OP_TAKEQ,
    OP_EMIT_VAL,
    OP_EMIT_BLK,
    OP_HOLD,
    OP_STEP,
    OP_ZERO,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RCHK,
    ST_RWAIT,
    ST_DISP,
    ST_UPI,
    ST_C_PA,
    ST_C_M1,
    ST_C_M2,
    ST_C_DIV,
    ST_C_WAIT,
    ST_SINK,
    ST_S_CHK,
    ST_A_WAIT,
    ST_A_EMIT,
    ST_HOLD,
    ST_LOOP,
    ST_FLUSH,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [2:0] {
    PH_CROSS1,
    PH_LOOP,
    PH_CROSS2,
    PH_FLUSH,
    PH_DNI
  } phase_e;

  typedef struct packed {
    dp_op_e op;
    logic   nxt_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic  rate_err;
    logic  div_done;
    mode_e mode;
    logic  blk_done;
    logic  step_more;
    logic  last;
    logic  seen;
    logic  k_zero;
    logic  cnt_zero;
    logic  rep_last;
    logic  can_emit;
  } dp_sts_t;

endpackage

// File: design/rrar_intf.sv
// request channels of the resampler: input, output and register write
// depends on rrar_pkg
interface rrar_in_if #(parameter int W = 24) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;
  logic                last;
  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface rrar_out_if #(parameter int W = 24) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_sample;
  logic                run_last;
  logic                stream_end;
  logic                rate_error;
  modport source (output valid, out_sample, run_last, stream_end, rate_error, input ready);
  modport sink (input valid, out_sample, run_last, stream_end, rate_error, output ready);
endinterface

interface rrar_cfg_if import rrar_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [RateW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/rrar_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module rrar_div #(
  parameter int NumW = 44,
  parameter int DenW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   trial;
  logic            ge;

  always_comb begin
    trial = {rem_q, quo_q[NumW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
    quo_d = {quo_q[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: design/rrar_dp.sv
// resampler datapath: rate registers, stream state, shared multiplier,
// divider and the pending/output result registers; depends on rrar_pkg, rrar_div
module rrar_dp import rrar_pkg::*; #(
  parameter int SampleBits = 24,
  parameter int MaxUpRatio = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  output dp_sts_t                      sts_o,
  input  logic signed [SampleBits-1:0] in_sample_i,
  input  logic                         in_last_i,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [RateW-1:0]             cfg_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [SampleBits-1:0] out_sample_o,
  output logic                         out_run_last_o,
  output logic                         out_stream_end_o,
  output logic                         out_rate_error_o
);

  localparam int KW    = $clog2(MaxUpRatio + 2);
  localparam int PaW   = RateW + KW;
  localparam int SumW  = SampleBits + KW + 1;
  localparam int NumW  = SampleBits + RateW + 2;
  localparam int DenW  = RateW + 2;
  localparam int ProdW = SampleBits + RateW + 1;

  logic [RateW-1:0]             src_q, dst_q;
  logic signed [SampleBits-1:0] x_q, held_q, val_q;
  logic                         last_q, seen_q, err_q;
  logic [PaW-1:0]               pa_q, r_q;
  logic [KW-1:0]                k_q, cnt_q, rep_q;
  logic signed [SumW-1:0]       sum_q;
  logic signed [NumW-1:0]       acc_q;
  mode_e                        mode_q;
  logic [EmitCntW-1:0]          emit_cnt_q;
  logic                         pend_v_q, pend_err_q;
  logic signed [SampleBits-1:0] pend_val_q;
  logic                         out_v_q, out_rl_q, out_se_q, out_err_q;
  logic signed [SampleBits-1:0] out_val_q;

  // rate checks
  logic           s_lt_d, rate_err;
  logic [PaW-1:0] s_m, d_m;
  logic [RateW-1:0] max_rate, min_rate;

  always_comb begin
    s_lt_d   = src_q < dst_q;
    max_rate = s_lt_d ? dst_q : src_q;
    min_rate = s_lt_d ? src_q : dst_q;
    s_m      = PaW'(src_q) * PaW'(MaxUpRatio);
    d_m      = PaW'(dst_q) * PaW'(MaxUpRatio);
    rate_err = (src_q == '0) || (dst_q == '0) || (PaW'(dst_q) > s_m) || (PaW'(src_q) > d_m);
  end

  // blend multiplier, one product per cycle
  logic [RateW-1:0]             p_w, sp_w;
  logic signed [SampleBits-1:0] nxt_w, mul_a;
  logic signed [RateW:0]        mul_b;
  logic signed [ProdW-1:0]      prod_w;
  logic signed [NumW-1:0]       prod_x;

  always_comb begin
    p_w    = pa_q[RateW-1:0];
    sp_w   = src_q - p_w;
    nxt_w  = cmd_i.nxt_zero ? '0 : x_q;
    mul_a  = (cmd_i.op == OP_MUL1) ? held_q : nxt_w;
    mul_b  = (cmd_i.op == OP_MUL1) ? $signed({1'b0, sp_w}) : $signed({1'b0, p_w});
    prod_w = mul_a * mul_b;
    prod_x = {{(NumW-ProdW){prod_w[ProdW-1]}}, prod_w};
  end

  // divider operand selection; blends and block averages round to nearest with ties up
  logic [NumW-1:0] half_s, bl_u, bl_num, sum_x, half_k, av_u, av_num, div_num;
  logic [DenW-1:0] div_den;
  logic            div_start, div_done;
  logic [NumW-1:0] div_quo;
  logic [DenW-1:0] div_rem;
  logic signed [SampleBits-1:0] q_val;

  always_comb begin
    half_s  = NumW'(src_q) << (SampleBits - 1);
    bl_u    = acc_q + half_s;
    bl_num  = {bl_u[NumW-2:0], 1'b0} + NumW'(src_q);
    sum_x   = {{(NumW-SumW){sum_q[SumW-1]}}, sum_q};
    half_k  = NumW'(k_q) << (SampleBits - 1);
    av_u    = sum_x + half_k;
    av_num  = {av_u[NumW-2:0], 1'b0} + NumW'(k_q);
    div_start = 1'b0;
    div_num   = NumW'(max_rate);
    div_den   = DenW'(min_rate);
    case (cmd_i.op)
      OP_RDIV: begin
        div_start = 1'b1;
      end
      OP_BDIV: begin
        div_start = 1'b1;
        div_num   = bl_num;
        div_den   = DenW'({src_q, 1'b0});
      end
      OP_ADIV: begin
        div_start = 1'b1;
        div_num   = av_num;
        div_den   = DenW'({k_q, 1'b0});
      end
      default: ;
    endcase
    // subtracting the offset of half the range flips the top bit
    q_val = $signed({~div_quo[SampleBits-1], div_quo[SampleBits-2:0]});
  end

  rrar_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // phase arithmetic
  logic [PaW:0]   pa_sum;
  logic [PaW-1:0] pa_wrap;
  logic [KW-1:0]  quot, k1;
  logic [PaW-1:0] r_dn;

  always_comb begin
    pa_sum  = {1'b0, pa_q} + (PaW+1)'(src_q);
    pa_wrap = (pa_sum >= {1'b0, r_q}) ? PaW'(pa_sum - {1'b0, r_q}) : pa_sum[PaW-1:0];
    quot    = div_quo[KW-1:0];
    k1      = quot + KW'(1);
    r_dn    = PaW'(dst_q) * PaW'(k1);
  end

  // emission
  logic                         do_emit, room, out_free, clr_stream;
  logic signed [SampleBits-1:0] emit_v;

  always_comb begin
    do_emit = (cmd_i.op == OP_EMIT_X) || (cmd_i.op == OP_EMIT_VAL) ||
              (cmd_i.op == OP_EMIT_BLK);
    emit_v  = (cmd_i.op == OP_EMIT_X) ? x_q : val_q;
    room    = emit_cnt_q < EmitCntW'(MaxResults);
    out_free = !out_v_q || out_ready_i;
    clr_stream = (cmd_i.op == OP_FINISH) && last_q && !err_q;
  end

  // configuration and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= RateReset;
      dst_q  <= RateReset;
      held_q <= '0;
      pa_q   <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SRC_RATE || cfg_idx_i == CFG_DST_RATE) begin
        held_q <= '0;
        pa_q   <= '0;
        sum_q  <= '0;
        cnt_q  <= '0;
        seen_q <= 1'b0;
      end
      if (cfg_idx_i == CFG_SRC_RATE) begin
        src_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_DST_RATE) begin
        dst_q <= cfg_data_i;
      end
    end else if (clr_stream) begin
      held_q <= '0;
      pa_q   <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_CROSS_PA: pa_q <= pa_wrap;
        OP_STEP:     pa_q <= pa_sum[PaW-1:0];
        OP_HOLD: begin
          held_q <= x_q;
          seen_q <= 1'b1;
        end
        OP_ACC: begin
          sum_q <= sum_q + {{(SumW-SampleBits){val_q[SampleBits-1]}}, val_q};
          cnt_q <= cnt_q + KW'(1);
        end
        OP_EMIT_BLK: begin
          sum_q <= '0;
          cnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // per item working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q   <= in_sample_i;
        val_q <= in_sample_i;
      end
      OP_RSET: begin
        if (s_lt_d) begin
          k_q <= (div_rem == '0) ? quot : '0;
          r_q <= PaW'(dst_q);
        end else begin
          k_q <= (div_rem == '0) ? quot : k1;
          r_q <= r_dn;
        end
        if (div_rem == '0) begin
          mode_q <= s_lt_d ? MODE_UP_INT : MODE_DN_INT;
        end else begin
          mode_q <= MODE_FRAC;
        end
      end
      OP_MUL1:  acc_q <= prod_x;
      OP_MUL2:  acc_q <= acc_q + prod_x;
      OP_TAKEQ: val_q <= q_val;
      OP_STEP:  val_q <= held_q;
      OP_ZERO:  val_q <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= 1'b0;
      err_q      <= 1'b0;
      rep_q      <= '0;
      emit_cnt_q <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cmd_i.op == OP_LOAD) begin
        last_q     <= in_last_i;
        err_q      <= 1'b0;
        rep_q      <= '0;
        emit_cnt_q <= '0;
      end
      if (cmd_i.op == OP_ERR) begin
        err_q <= 1'b1;
      end
      if (cmd_i.op == OP_EMIT_X) begin
        rep_q <= rep_q + KW'(1);
      end
      if (do_emit && room) begin
        emit_cnt_q <= emit_cnt_q + EmitCntW'(1);
      end
      // pending result moves on when a newer one arrives or the item ends
      if (pend_v_q && ((do_emit && room) || cmd_i.op == OP_FINISH)) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if ((do_emit && room) || cmd_i.op == OP_ERR) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.op == OP_FINISH) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_v_q && ((do_emit && room) || cmd_i.op == OP_FINISH)) begin
      out_val_q <= pend_val_q;
      out_err_q <= pend_err_q;
      out_rl_q  <= cmd_i.op == OP_FINISH;
      out_se_q  <= (cmd_i.op == OP_FINISH) && last_q;
    end
    if (do_emit && room) begin
      pend_val_q <= emit_v;
      pend_err_q <= 1'b0;
    end else if (cmd_i.op == OP_ERR) begin
      pend_val_q <= '0;
      pend_err_q <= 1'b1;
    end
  end

  always_comb begin
    sts_o.rate_err  = rate_err;
    sts_o.div_done  = div_done;
    sts_o.mode      = mode_q;
    sts_o.blk_done  = cnt_q >= k_q;
    sts_o.step_more = pa_sum < {1'b0, r_q};
    sts_o.last      = last_q;
    sts_o.seen      = seen_q;
    sts_o.k_zero    = k_q == '0;
    sts_o.cnt_zero  = cnt_q == '0;
    sts_o.rep_last  = ({1'b0, rep_q} + (KW+1)'(1)) >= {1'b0, k_q};
    sts_o.can_emit  = !pend_v_q || out_free;
  end

  assign out_valid_o      = out_v_q;
  assign out_sample_o     = out_val_q;
  assign out_run_last_o   = out_rl_q;
  assign out_stream_end_o = out_se_q;
  assign out_rate_error_o = out_err_q;

endmodule

// File: design/rrar_ctrl.sv
// resampler sequencer: walks one input request through rate decode, integer
// repeats, interpolation crossings, block averaging and flush; depends on rrar_pkg
module rrar_ctrl import rrar_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  phase_e      ph_q, ph_d;
  ctrl_state_e ret_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_CROSS1;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  // where a finished sink step goes back to
  always_comb begin
    unique case (ph_q)
      PH_CROSS1: ret_st = ST_HOLD;
      PH_LOOP:   ret_st = ST_LOOP;
      PH_CROSS2: ret_st = ST_FLUSH;
      PH_FLUSH:  ret_st = ST_FLUSH;
      PH_DNI:    ret_st = ST_FIN;
      default:   ret_st = ST_FIN;
    endcase
  end

  always_comb begin
    state_d        = state_q;
    ph_d           = ph_q;
    cmd_o.op       = OP_NONE;
    cmd_o.nxt_zero = ph_q == PH_CROSS2;
    in_ready_o     = state_q == ST_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_RCHK;
        end
      end
      ST_RCHK: begin
        if (sts_i.rate_err) begin
          cmd_o.op = OP_ERR;
          state_d  = ST_FIN;
        end else begin
          cmd_o.op = OP_RDIV;
          state_d  = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_RSET;
          state_d  = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts_i.mode)
          MODE_UP_INT: state_d = ST_UPI;
          MODE_DN_INT: begin
            cmd_o.op = OP_ACC;
            ph_d     = PH_DNI;
            state_d  = ST_S_CHK;
          end
          default: begin
            ph_d    = PH_CROSS1;
            state_d = sts_i.seen ? ST_C_PA : ST_HOLD;
          end
        endcase
      end
      ST_UPI: begin
        if (sts_i.can_emit) begin
          cmd_o.op = OP_EMIT_X;
          if (sts_i.rep_last) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_C_PA: begin
        cmd_o.op = OP_CROSS_PA;
        state_d  = ST_C_M1;
      end
      ST_C_M1: begin
        cmd_o.op = OP_MUL1;
        state_d  = ST_C_M2;
      end
      ST_C_M2: begin
        cmd_o.op = OP_MUL2;
        state_d  = ST_C_DIV;
      end
      ST_C_DIV: begin
        cmd_o.op = OP_BDIV;
        state_d  = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_TAKEQ;
          state_d  = ST_SINK;
        end
      end
      ST_SINK: begin
        if (sts_i.k_zero) begin
          if (sts_i.can_emit) begin
            cmd_o.op = OP_EMIT_VAL;
            state_d  = ret_st;
          end
        end else begin
          cmd_o.op = OP_ACC;
          state_d  = ST_S_CHK;
        end
      end
      ST_S_CHK: begin
        // integer downsampling closes a short block at the end of the stream
        if (sts_i.blk_done || (ph_q == PH_DNI && sts_i.last)) begin
          cmd_o.op = OP_ADIV;
          state_d  = ST_A_WAIT;
        end else begin
          state_d = ret_st;
        end
      end
      ST_A_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_TAKEQ;
          state_d  = ST_A_EMIT;
        end
      end
      ST_A_EMIT: begin
        if (sts_i.can_emit) begin
          cmd_o.op = OP_EMIT_BLK;
          state_d  = ret_st;
        end
      end
      ST_HOLD: begin
        cmd_o.op = OP_HOLD;
        state_d  = ST_LOOP;
      end
      ST_LOOP: begin
        if (sts_i.step_more) begin
          cmd_o.op = OP_STEP;
          ph_d     = PH_LOOP;
          state_d  = ST_SINK;
        end else if (sts_i.last) begin
          ph_d    = PH_CROSS2;
          state_d = ST_C_PA;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.k_zero && !sts_i.cnt_zero) begin
          cmd_o.op = OP_ZERO;
          ph_d     = PH_FLUSH;
          state_d  = ST_SINK;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.can_emit) begin
          cmd_o.op = OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: design/rational_rate_audio_resampler.sv
// Rational rate mono resampler for Q1.23 samples.
// Channels: in_i takes one sample request with a last flag, out_o gives the
// resampled samples of that request with run_last on the final one, stream_end
// on the final sample of the stream and rate_error when a rate is zero or their
// ratio is outside 1..MAX_UP_RATIO in either direction. cfg_i writes src_rate
// (index 0) or dst_rate (index 1); a write restarts the stream and is meant for
// idle time. One request is worked at a time. Every request with valid rates first
// divides the two rates on the shared 44-step restoring divider, which then also
// forms each interpolated value and each block average; a repeated sample in
// integer upsampling needs no division. A finished result waits in a pending
// register and then in the output register, so when the receiver stalls the block
// runs on until a second result has to leave, and holds there. After reset both
// rates are 48000 and the stream state is clear; no clearing pass is needed.
module rational_rate_audio_resampler import rrar_pkg::*; #(
  parameter int SAMPLE_BITS  = 24,
  parameter int MAX_UP_RATIO = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrar_in_if.sink           in_i,
  rrar_out_if.source        out_o,
  rrar_cfg_if.sink          cfg_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  rrar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrar_dp #(
    .SampleBits (SAMPLE_BITS),
    .MaxUpRatio (MAX_UP_RATIO)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_sample_i      (in_i.sample),
    .in_last_i        (in_i.last),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_sample_o     (out_o.out_sample),
    .out_run_last_o   (out_o.run_last),
    .out_stream_end_o (out_o.stream_end),
    .out_rate_error_o (out_o.rate_error)
  );

endmodule

// File: design/rrar_chk.sv
// port level checks of the resampler, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module rrar_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_run_last_i,
  input logic out_stream_end_i,
  input logic out_rate_error_i
);

  // one request at a time: busy right after taking one
  `RRAR_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i)
  `RRAR_ASSERT_NEVER(a_err_alone, out_valid_i && out_rate_error_i && !out_run_last_i)
  `RRAR_ASSERT(a_end_is_run_last, out_valid_i && out_stream_end_i |-> out_run_last_i)
  `RRAR_ASSERT(a_out_held, out_valid_i && !out_ready_i |=> out_valid_i)

endmodule

bind rational_rate_audio_resampler rrar_chk u_rrar_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_run_last_i   (out_o.run_last),
  .out_stream_end_i (out_o.stream_end),
  .out_rate_error_i (out_o.rate_error)
);

// File: bench/rational_rate_audio_resampler_tb.sv
// self-checking bench of the rational rate resampler: directed table, then random streams
// over many rate settings. Every request is predicted in SV and the results compared in order.
// depends on rrar_pkg, rrar_intf and rational_rate_audio_resampler
module rational_rate_audio_resampler_tb;
  import rrar_pkg::*;

  localparam int  SampleW    = 24;
  localparam int  UpRatio    = 32;
  localparam int  ItemTarget = 420;
  localparam int  QuietFrom  = 380;
  localparam int  CycleLimit = 3000000;
  localparam int  SettleCyc  = 4000;
  localparam logic signed [SampleW-1:0] SMax = 24'sh7fffff;
  localparam logic signed [SampleW-1:0] SMin = 24'sh800000;

  typedef struct {
    logic signed [SampleW-1:0] smp;
    logic                      run_last;
    logic                      stream_end;
    logic                      rate_error;
  } resample_out_t;

  typedef struct {
    bit                        is_cfg;
    logic [CfgIdxW-1:0]        idx;
    int                        data;
    logic signed [SampleW-1:0] smp;
    bit                        last;
    bit                        typed;
    logic signed [SampleW-1:0] exp_smp;
    bit                        exp_end;
    bit                        exp_err;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rrar_in_if  #(SampleW) in_if ();
  rrar_out_if #(SampleW) out_if ();
  rrar_cfg_if            cfg_if ();

  rational_rate_audio_resampler #(.SAMPLE_BITS(SampleW), .MAX_UP_RATIO(UpRatio)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  int unsigned   src_hz, dst_hz;
  longint        held_x, blk_sum;
  int unsigned   phase, blk_cnt;
  bit            have_x;
  resample_out_t expected_q[$];
  resample_out_t item_res[$];

  int  fails;
  int  items_sent;
  bit  quiet;
  int  cycles;

  function automatic longint round_q(longint num, longint den);
    longint half, u, q;
    half = longint'(1) << (SampleW - 1);
    u = num + half * den;
    q = (2 * u + den) / (2 * den);
    return q - half;
  endfunction

  function automatic void emit_val(longint v);
    resample_out_t r;
    if (item_res.size() >= MaxResults) return;
    r.smp = v[SampleW-1:0];
    r.run_last = 1'b0;
    r.stream_end = 1'b0;
    r.rate_error = 1'b0;
    item_res.push_back(r);
  endfunction

  function automatic void avg_or_emit(longint v, int unsigned k);
    if (k == 0) begin
      emit_val(v);
      return;
    end
    blk_sum += v;
    blk_cnt++;
    if (blk_cnt >= k) begin
      emit_val(round_q(blk_sum, k));
      blk_sum = 0;
      blk_cnt = 0;
    end
  endfunction

  function automatic void blend_step(longint nxt, int unsigned s, int unsigned r, int unsigned k);
    longint p;
    phase += s;
    if (phase >= r) phase -= r;
    p = phase;
    avg_or_emit(round_q(held_x * (longint'(s) - p) + nxt * p, s), k);
  endfunction

  function automatic void interp(longint x, bit last, int unsigned s, int unsigned r,
                                 int unsigned k);
    if (have_x) blend_step(x, s, r, k);
    held_x = x;
    have_x = 1'b1;
    while (phase + s < r) begin
      phase += s;
      avg_or_emit(held_x, k);
    end
    if (last) begin
      blend_step(0, s, r, k);
      if (k != 0)
        while (blk_cnt != 0) avg_or_emit(0, k);
    end
  endfunction

  function automatic void clear_stream();
    held_x = 0;
    phase = 0;
    blk_sum = 0;
    blk_cnt = 0;
    have_x = 1'b0;
  endfunction

  // works out the results of one accepted sample request
  function automatic void predict_request(logic signed [SampleW-1:0] smp, bit last,
                                          output resample_out_t res[$]);
    longint      x;
    int unsigned k, kk;
    resample_out_t r;
    x = smp;
    item_res.delete();
    if (src_hz == 0 || dst_hz == 0 || longint'(dst_hz) > longint'(UpRatio) * src_hz ||
        longint'(src_hz) > longint'(UpRatio) * dst_hz) begin
      r.smp = '0;
      r.run_last = 1'b1;
      r.stream_end = last;
      r.rate_error = 1'b1;
      res = {r};
      return;
    end
    if (src_hz < dst_hz) begin
      k = dst_hz / src_hz;
      if (k * src_hz == dst_hz) begin
        for (int i = 0; i < k; i++) emit_val(x);
      end else begin
        interp(x, last, src_hz, dst_hz, 0);
      end
    end else begin
      k = src_hz / dst_hz;
      if (k * dst_hz == src_hz) begin
        blk_sum += x;
        blk_cnt++;
        if (blk_cnt >= k || last) begin
          emit_val(round_q(blk_sum, k));
          blk_sum = 0;
          blk_cnt = 0;
        end
      end else begin
        kk = (src_hz + dst_hz - 1) / dst_hz;
        interp(x, last, src_hz, dst_hz * kk, kk);
      end
    end
    if (last) clear_stream();
    if (item_res.size() > 0) begin
      item_res[$].run_last = 1'b1;
      item_res[$].stream_end = last;
    end
    res = item_res;
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic write_rate(logic [CfgIdxW-1:0] idx, int unsigned val);
    // block must be idle: drain expectations, then let any silent work finish
    in_if.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[RateW-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_SRC_RATE) src_hz = val;
    else dst_hz = val;
    clear_stream();
  endtask

  task automatic send_sample(logic signed [SampleW-1:0] smp, bit last, bit typed,
                             resample_out_t typed_res);
    resample_out_t res[$];
    in_if.valid  <= 1'b1;
    in_if.sample <= smp;
    in_if.last   <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_request(smp, last, res);
    if (typed) res = {typed_res};
    foreach (res[i]) expected_q.push_back(res[i]);
    items_sent++;
    if (items_sent >= QuietFrom) quiet = 1'b1;
    idle_burst();
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SMax;
      1: return SMin;
      2: return SampleW'($urandom_range(0, 16)) - 24'sd8;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // output side: random stall bursts
  int stall_left;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    resample_out_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_sample %0d", out_if.out_sample);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (out_if.out_sample !== e.smp) begin
          $error("out_sample expected %0d actual %0d", e.smp, out_if.out_sample);
          fails++;
        end
        if (out_if.run_last !== e.run_last) begin
          $error("run_last expected %0b actual %0b", e.run_last, out_if.run_last);
          fails++;
        end
        if (out_if.stream_end !== e.stream_end) begin
          $error("stream_end expected %0b actual %0b", e.stream_end, out_if.stream_end);
          fails++;
        end
        if (out_if.rate_error !== e.rate_error) begin
          $error("rate_error expected %0b actual %0b", e.rate_error, out_if.rate_error);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  stim_row_t dir_tab[$];

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, int val);
    stim_row_t r;
    r = '{default: 0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = val;
    return r;
  endfunction

  function automatic stim_row_t smp_row(logic signed [SampleW-1:0] smp, bit last, bit typed,
                                        logic signed [SampleW-1:0] es, bit ee, bit er);
    stim_row_t r;
    r = '{default: 0};
    r.smp = smp;
    r.last = last;
    r.typed = typed;
    r.exp_smp = es;
    r.exp_end = ee;
    r.exp_err = er;
    return r;
  endfunction

  initial begin
    resample_out_t tr;
    int unsigned s, d, lo, hi, len;
    int phase_no;
    bit drained;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SRC_RATE;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    stall_left = 0;
    fails = 0;
    items_sent = 0;
    quiet = 1'b0;
    cycles = 0;
    drained = 1'b0;
    src_hz = RateReset;
    dst_hz = RateReset;
    clear_stream();

    // after reset 1:1, every sample passes straight through
    dir_tab.push_back(smp_row(SMax, 0, 1, SMax, 0, 0));
    dir_tab.push_back(smp_row(SMin, 0, 1, SMin, 0, 0));
    dir_tab.push_back(smp_row(24'sh555555, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(24'shaaaaaa, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(0, 1, 1, 0, 1, 0));
    // ratio beyond the bound, both directions
    dir_tab.push_back(cfg_row(CFG_SRC_RATE, 1));
    dir_tab.push_back(cfg_row(CFG_DST_RATE, 192000));
    dir_tab.push_back(smp_row(123, 0, 1, 0, 0, 1));
    dir_tab.push_back(smp_row(-5, 1, 1, 0, 1, 1));
    dir_tab.push_back(cfg_row(CFG_SRC_RATE, 192000));
    dir_tab.push_back(cfg_row(CFG_DST_RATE, 1));
    dir_tab.push_back(smp_row(SMax, 1, 1, 0, 1, 1));
    // integer up by the full ratio
    dir_tab.push_back(cfg_row(CFG_SRC_RATE, 1));
    dir_tab.push_back(cfg_row(CFG_DST_RATE, 32));
    dir_tab.push_back(smp_row(SMax, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(SMin, 1, 0, 0, 0, 0));
    // fractional up
    dir_tab.push_back(cfg_row(CFG_SRC_RATE, 3));
    dir_tab.push_back(cfg_row(CFG_DST_RATE, 7));
    dir_tab.push_back(smp_row(100, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(-100, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(SMax, 1, 0, 0, 0, 0));
    // integer down by the full ratio, flush on a partial block
    dir_tab.push_back(cfg_row(CFG_SRC_RATE, 192000));
    dir_tab.push_back(cfg_row(CFG_DST_RATE, 6000));
    dir_tab.push_back(smp_row(SMin, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(SMin, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(SMax, 1, 0, 0, 0, 0));
    // fractional down
    dir_tab.push_back(cfg_row(CFG_SRC_RATE, 7));
    dir_tab.push_back(cfg_row(CFG_DST_RATE, 3));
    dir_tab.push_back(smp_row(SMax, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(SMax, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(-7, 0, 0, 0, 0, 0));
    dir_tab.push_back(smp_row(SMin, 1, 0, 0, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_rate(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        tr.smp = dir_tab[i].exp_smp;
        tr.run_last = 1'b1;
        tr.stream_end = dir_tab[i].exp_end;
        tr.rate_error = dir_tab[i].exp_err;
        send_sample(dir_tab[i].smp, dir_tab[i].last, dir_tab[i].typed, tr);
      end
    end

    phase_no = 0;
    while (items_sent < ItemTarget) begin
      case (phase_no)
        0: begin s = 48000; d = 44100; end
        1: begin s = 44100; d = 48000; end
        2: begin s = 8000; d = 48000; end
        3: begin s = 48000; d = 8000; end
        4: begin s = 5; d = 159; end
        5: begin s = 159; d = 5; end
        6: begin s = 6000; d = 192000; end
        7: begin s = 1; d = 33; end
        8: begin s = 192000; d = 192000; end
        default: begin
          s = $urandom_range(1, 192000);
          lo = (s + UpRatio - 1) / UpRatio;
          hi = (s * UpRatio > 192000) ? 192000 : s * UpRatio;
          d = $urandom_range(lo, hi);
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_rate(CFG_SRC_RATE, s);
        write_rate(CFG_DST_RATE, d);
      end else begin
        write_rate(CFG_DST_RATE, d);
        write_rate(CFG_SRC_RATE, s);
      end
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
          if (!drained && items_sent > 200) begin
            // hold the sender until everything in flight has come out
            in_if.valid <= 1'b0;
            wait (expected_q.size() == 0);
            @(posedge clk_i);
            drained = 1'b1;
          end
          send_sample(rand_sample(), i == len - 1, 0, tr);
        end
      end
      phase_no++;
    end
    in_if.valid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
